// ===== hdl/rsws_pkg.sv =====
// ----------------------------------------------------------------------------
// Range sample window statistics package
// Shared types, codes and constants for the window statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsws_pkg;

  localparam int DefaultHistoryDepth = 60;

  localparam int DistW = 16;
  localparam int SumW  = 24;
  localparam int CntW  = 8;

  localparam logic [CntW-1:0]  COUNT_LIMIT     = 8'd255;
  localparam logic [DistW-1:0] DIST_MAX        = 16'hFFFF;
  localparam logic [DistW-1:0] PROX_LIMIT_RST  = 16'd100;

  localparam logic [1:0] KIND_GOOD = 2'd0;
  localparam logic [1:0] KIND_FAIL = 2'd1;

  localparam logic [7:0] MIN_LEN_GOOD = 8'd2;
  localparam logic [7:0] MIN_LEN_FAIL = 8'd1;

  localparam int CfgAddrW = 3;
  localparam logic REG_PROX_LIMIT = 1'b0;
  localparam logic REG_SOURCE_ID  = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       source_id;
    logic [7:0]       payload_len;
    logic [DistW-1:0] distance_mm;
    logic [7:0]       error_code;
  } report_t;

  typedef struct packed {
    logic [DistW-1:0] latest_mm;
    logic             data_valid;
    logic             out_of_range;
    logic             proximity_hit;
    logic [7:0]       last_error;
    logic [5:0]       stored_count;
    logic [DistW-1:0] average_mm;
    logic [DistW-1:0] minimum_mm;
    logic [DistW-1:0] maximum_mm;
  } stats_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/rsws_ram.sv =====
// ----------------------------------------------------------------------------
// Generic sample RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsws_ram #(
  parameter int Width = 16,
  parameter int Depth = 60
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/rsws_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of the running sum by the running count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsws_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rsws_pkg::div_req_t req_i,
  output rsws_pkg::div_rsp_t      rsp_o
);

  import rsws_pkg::*;

  localparam int StepW = $clog2(SumW + 1);
  localparam logic [StepW-1:0] StepLast = StepW'(SumW - 1);

  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dsr_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;
  logic [CntW:0]    trial;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[SumW-1]};
    fits  = (trial >= {1'b0, dsr_q});
    rem_d = fits ? CntW'(trial - {1'b0, dsr_q}) : trial[CntW-1:0];
    quo_d = {quo_q[SumW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== hdl/range_sample_window_stats_top.sv =====
// ----------------------------------------------------------------------------
// Range sample window statistics
// Filters ranging reports, keeps a ring of recent distances and reports
// latest reading, flags, average and ring minimum and maximum.
// ----------------------------------------------------------------------------
// One report is taken at a time. A report from another source, of an unknown
// kind or with a short payload is dropped in its accept cycle and gives no
// beat. An accepted report is worked on in order: the ring is read one entry
// per cycle through the single RAM read port to find minimum, maximum and,
// after 255 samples, the rebuilt sum; the average then comes from a divider
// that makes one quotient bit per cycle and is skipped while no good sample
// has arrived.
// in_stall_o stays high until the result beat is loaded into the output
// register, which may hold it while the next report is being worked on.
`default_nettype none

module range_sample_window_stats_top #(
  parameter int HistoryDepth = rsws_pkg::DefaultHistoryDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire rsws_pkg::report_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output rsws_pkg::stats_t                   out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rsws_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import rsws_pkg::*;

  localparam int AddrW = $clog2(HistoryDepth);
  localparam int FillW = $clog2(HistoryDepth + 1);
  localparam logic [AddrW-1:0] PtrLast  = AddrW'(HistoryDepth - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(HistoryDepth);

  state_e state_q, state_d;

  logic [DistW-1:0] prox_limit_q;
  logic [7:0]       source_id_q;

  logic [AddrW-1:0] wptr_q;
  logic [FillW-1:0] fill_q;
  logic [SumW-1:0]  run_sum_q;
  logic [CntW-1:0]  run_cnt_q;
  logic [DistW-1:0] last_dist_q;
  logic             valid_flag_q;
  logic             failed_flag_q;
  logic [7:0]       error_q;
  logic             rebuild_q;

  logic [FillW-1:0] idx_q;
  logic             pend_q;
  logic [DistW-1:0] min_q;
  logic [DistW-1:0] max_q;
  logic [SumW-1:0]  scan_sum_q;
  logic [DistW-1:0] avg_q;

  logic             out_valid_q;
  stats_t           out_data_q;

  logic             cfg_wr;
  logic             in_acc;
  logic             src_ok;
  logic             is_good;
  logic             is_fail;
  logic             scan_more;
  logic             scan_done;
  logic             out_free;
  logic             scan_run;
  logic             div_go;
  logic             out_load;
  logic [DistW-1:0] rd_data;
  logic [CntW-1:0]  fill_ext;
  logic             close;
  stats_t           stats;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prox_limit_q <= PROX_LIMIT_RST;
      source_id_q  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PROX_LIMIT: prox_limit_q <= pwdata[DistW-1:0];
        REG_SOURCE_ID:  source_id_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PROX_LIMIT: prdata = 32'(prox_limit_q);
      REG_SOURCE_ID:  prdata = 32'(source_id_q);
      default:        prdata = '0;
    endcase
  end

  // Report filter
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign src_ok     = (in_data_i.source_id == source_id_q);
  assign is_good    = src_ok && (in_data_i.req_type == KIND_GOOD) &&
                      (in_data_i.payload_len >= MIN_LEN_GOOD);
  assign is_fail    = src_ok && (in_data_i.req_type == KIND_FAIL) &&
                      (in_data_i.payload_len >= MIN_LEN_FAIL);

  assign scan_more = (idx_q < fill_q);
  assign scan_done = !scan_more && !pend_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && (is_good || is_fail)) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_DSTART;
      ST_DSTART: state_d = (run_cnt_q == '0) ? ST_FIN : ST_DWAIT;
      ST_DWAIT:  if (div_rsp.done) state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_run = 1'b0;
    div_go   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_SCAN:   scan_run = 1'b1;
      ST_DSTART: div_go   = (run_cnt_q != '0);
      ST_FIN:    out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q        <= '0;
      fill_q        <= '0;
      run_sum_q     <= '0;
      run_cnt_q     <= '0;
      last_dist_q   <= '0;
      valid_flag_q  <= 1'b0;
      failed_flag_q <= 1'b0;
      error_q       <= '0;
      rebuild_q     <= 1'b0;
    end else begin
      if (in_acc && is_good) begin
        last_dist_q   <= in_data_i.distance_mm;
        valid_flag_q  <= 1'b1;
        failed_flag_q <= 1'b0;
        wptr_q        <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
        if (fill_q != FillFull) begin
          fill_q <= fill_q + 1'b1;
        end
        if (run_cnt_q != COUNT_LIMIT) begin
          run_sum_q <= run_sum_q + SumW'(in_data_i.distance_mm);
          run_cnt_q <= run_cnt_q + 1'b1;
          rebuild_q <= 1'b0;
        end else begin
          rebuild_q <= 1'b1;
        end
      end else if (in_acc && is_fail) begin
        error_q       <= in_data_i.error_code;
        failed_flag_q <= 1'b1;
        rebuild_q     <= 1'b0;
      end else if (scan_run && scan_done && rebuild_q) begin
        run_sum_q <= scan_sum_q;
        run_cnt_q <= fill_ext;
        rebuild_q <= 1'b0;
      end
    end
  end

  assign fill_ext = CntW'(fill_q);

  // Ring scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (in_acc) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (scan_run) begin
      pend_q <= scan_more;
      if (scan_more) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      min_q      <= DIST_MAX;
      max_q      <= '0;
      scan_sum_q <= '0;
    end else if (scan_run && pend_q) begin
      if (rd_data < min_q) begin
        min_q <= rd_data;
      end
      if (rd_data > max_q) begin
        max_q <= rd_data;
      end
      scan_sum_q <= scan_sum_q + SumW'(rd_data);
    end
  end

  rsws_ram #(
    .Width (DistW),
    .Depth (HistoryDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc && is_good),
    .waddr_i (wptr_q),
    .wdata_i (in_data_i.distance_mm),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  // Average
  assign div_req.start    = div_go;
  assign div_req.dividend = run_sum_q;
  assign div_req.divisor  = run_cnt_q;

  rsws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (div_go) begin
      avg_q <= '0;
    end else if (state_q == ST_DSTART) begin
      avg_q <= '0;
    end else if (div_rsp.done) begin
      avg_q <= DistW'(div_rsp.quotient);
    end
  end

  // Result beat
  assign close = valid_flag_q && !failed_flag_q && (last_dist_q != '0) &&
                 (last_dist_q < prox_limit_q);

  always_comb begin
    stats.latest_mm     = last_dist_q;
    stats.data_valid    = valid_flag_q;
    stats.out_of_range  = failed_flag_q;
    stats.proximity_hit = close;
    stats.last_error    = error_q;
    stats.stored_count  = fill_ext[5:0];
    stats.average_mm    = avg_q;
    stats.minimum_mm    = (fill_q == '0) ? '0 : min_q;
    stats.maximum_mm    = (fill_q == '0) ? '0 : max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= stats;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("fill count above ring depth");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_flag_q |-> (run_cnt_q != '0))
    else $error("running count zero after a good sample");

  a_take_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (is_good || is_fail)) |=> (state_q == ST_SCAN))
    else $error("accepted report did not start a scan");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DWAIT))
    else $error("divider finished outside its wait state");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("held result beat lost or changed");

endmodule

`default_nettype wire
